FILE: design/sck_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package sck_pkg;

  // pending table entry: physical row, column, countdown
  typedef struct packed {
    logic [2:0] row;
    logic [4:0] col;
    logic [3:0] tick;
  } entry_t;

  localparam logic [3:0] TICK_RELEASING = 4'd1;
  localparam logic [3:0] TICK_PRESSED   = 4'd2;
  localparam logic [3:0] DELAY_MIN      = 4'd1;
  localparam logic [3:0] DELAY_MAX      = 4'd13;
  localparam logic [3:0] DELAY_RESET    = 4'd10;
  localparam logic [3:0] ROWS_RESET     = 4'd8;

  localparam logic REQ_SAMPLE = 1'b0;
  localparam logic REQ_TICK   = 1'b1;

  localparam logic EV_PRESS   = 1'b0;
  localparam logic EV_RELEASE = 1'b1;

  localparam logic REG_PRESS_DELAY = 1'b0;
  localparam logic REG_ROWS_IN_USE = 1'b1;

endpackage

`default_nettype wire

FILE: design/steno_chord_key_scanner.sv
`timescale 1ns / 1ps
`default_nettype none

// Steno chord key scanner.
// Input channel (in_valid/in_ready): one item is a key sample (row, col,
// released level) or an end-of-scan tick. Output channel (out_valid/out_ready):
// logical press/release events, "last" set on the final item an input causes;
// an input with no event gives one item with event_valid low and last high.
// Config channel (cfg_valid/cfg_ready, always ready): index 0 press delay,
// index 1 rows in use; write only while idle.
// The pending table lives in a single-port-write RAM with registered read.
// Each input walks it, reading and then checking each stored entry, with a
// setup and a finish step. A release that frees an entry adds a compaction
// pass that reads each entry behind it and writes it back one slot lower.
// One input is processed at a time; in_ready is high only when idle.
// Results go through an output register; a tick with several events keeps
// one held event and pushes the previous one out, so a stalled receiver
// stalls the table walk before any entry is modified.
// Reset (synchronous) empties the table by clearing its fill count, clears
// all key bitmaps and loads the default register values. No clearing pass.
module steno_chord_key_scanner
  import sck_pkg::*;
#(
  parameter int TABLE_DEPTH = 20,
  parameter int PHYS_ROWS   = 8,
  parameter int COLS        = 32
) (
  input  wire         clk,
  input  wire         rst,
  input  wire         in_valid,
  output logic        in_ready,
  input  wire         req_type,
  input  wire  [2:0]  phys_row,
  input  wire  [4:0]  col,
  input  wire         released,
  output logic        out_valid,
  input  wire         out_ready,
  output logic        event_valid,
  output logic        event_kind,
  output logic [3:0]  logical_row,
  output logic [4:0]  key_col,
  output logic        last,
  input  wire         cfg_valid,
  output logic        cfg_ready,
  input  wire         cfg_index,
  input  wire  [3:0]  cfg_data
);

  localparam int AW     = $clog2(TABLE_DEPTH);
  localparam int CW     = $clog2(TABLE_DEPTH + 1);
  localparam int KEYS   = PHYS_ROWS * COLS;
  localparam int LKEYS  = 2 * PHYS_ROWS * COLS;
  localparam int KEY_W  = $clog2(KEYS);
  localparam int LKEY_W = $clog2(LKEYS);

  typedef enum logic [9:0] {
    ST_IDLE  = 10'b0000000001,
    ST_T_RD  = 10'b0000000010,
    ST_T_CHK = 10'b0000000100,
    ST_S_RD  = 10'b0000001000,
    ST_S_CHK = 10'b0000010000,
    ST_S_ACT = 10'b0000100000,
    ST_S_WR2 = 10'b0001000000,
    ST_R_RD  = 10'b0010000000,
    ST_R_WR  = 10'b0100000000,
    ST_FIN   = 10'b1000000000
  } state_t;

  state_t state;

  // config registers
  logic [3:0] press_delay_ticks;
  logic [3:0] rows_in_use;

  // table RAM
  entry_t          mem [TABLE_DEPTH];
  entry_t          rdata;
  logic            mem_re;
  logic [AW-1:0]   mem_raddr;
  logic            mem_we;
  logic [AW-1:0]   mem_waddr;
  entry_t          mem_wdata;

  logic [CW-1:0]   count;
  logic [CW-1:0]   idx;

  // key bitmaps, flattened row-major
  logic [KEYS-1:0]  press_bits;
  logic [KEYS-1:0]  releasing_bits;
  logic [LKEYS-1:0] logical_pressed;

  // captured sample
  logic [2:0] s_row;
  logic [4:0] s_col;
  logic       s_up;

  // lookup results of the walk
  logic          f_self, f_up, f_dn;
  logic [AW-1:0] i_self, i_up, i_dn;
  logic [3:0]    t_up, t_dn;

  // chord partner for the second write
  logic [AW-1:0] part_idx;
  logic [2:0]    part_row;

  // held event
  logic       hold_valid;
  logic       hold_kind;
  logic [3:0] hold_row;
  logic [4:0] hold_col;

  // output register
  logic       res_valid;
  logic       res_ev;
  logic       res_kind;
  logic [3:0] res_row;
  logic [4:0] res_col;
  logic       res_last;

  function automatic logic [KEY_W-1:0] key_idx(input logic [3:0] r, input logic [4:0] c);
    key_idx = KEY_W'(int'(r) * COLS + int'(c));
  endfunction

  function automatic logic [LKEY_W-1:0] lkey_idx(input logic [3:0] r, input logic [4:0] c);
    lkey_idx = LKEY_W'(int'(r) * COLS + int'(c));
  endfunction

  // ---------------------------------------------------------------------
  // derived control
  logic [4:0]  eff_rows;
  logic        up_ok, dn_ok;
  logic        out_free;
  logic        in_ok;
  logic [3:0]  row_up, row_dn;
  logic [KEY_W-1:0] k_self, k_up, k_dn;
  logic        pb_self, rb_self;
  logic        act_rel, act_press;
  logic        rl_up, rl_dn;
  logic        ch_up, ch_dn, chord;
  logic [3:0]  lr_rel, lr_ch;
  logic        self_ok;
  logic [AW-1:0] self_addr;
  logic [3:0]  delay;
  logic        t_dec, t_emit, t_go;
  logic [3:0]  t_new;
  logic        idx_end;

  always_comb begin
    eff_rows = ({1'b0, rows_in_use} > 5'(PHYS_ROWS)) ? 5'(PHYS_ROWS) : {1'b0, rows_in_use};
    in_ok    = ({2'b00, phys_row} < eff_rows) && (int'(col) < COLS);
    row_up   = {1'b0, s_row} + 4'd1;
    row_dn   = {1'b0, s_row} - 4'd1;
    up_ok    = {1'b0, row_up} < eff_rows;
    dn_ok    = s_row != 3'd0;
    out_free = !res_valid || out_ready;
    idx_end  = idx == count;

    k_self  = key_idx({1'b0, s_row}, s_col);
    k_up    = key_idx(row_up, s_col);
    k_dn    = key_idx(row_dn, s_col);
    pb_self = press_bits[k_self];
    rb_self = releasing_bits[k_self];

    act_rel   = s_up && pb_self;
    act_press = !s_up && !pb_self && !rb_self;

    // release: chord partner from the logical map
    rl_up  = up_ok && logical_pressed[lkey_idx({s_row, 1'b1}, s_col)];
    rl_dn  = !rl_up && dn_ok && logical_pressed[lkey_idx({s_row, 1'b0} - 4'd1, s_col)];
    lr_rel = rl_up ? {s_row, 1'b1} : (rl_dn ? {s_row, 1'b0} - 4'd1 : {s_row, 1'b0});

    // press: chord partner still waiting in the table
    ch_up = up_ok && f_up && (t_up > TICK_PRESSED);
    ch_dn = !ch_up && dn_ok && f_dn && (t_dn > TICK_PRESSED);
    chord = ch_up || ch_dn;
    lr_ch = ch_up ? {s_row, 1'b1} : {s_row, 1'b0} - 4'd1;

    self_ok   = f_self || (int'(count) < TABLE_DEPTH);
    self_addr = f_self ? i_self : count[AW-1:0];

    if (press_delay_ticks == 4'd0) begin
      delay = DELAY_MIN;
    end else if (press_delay_ticks > DELAY_MAX) begin
      delay = DELAY_MAX;
    end else begin
      delay = press_delay_ticks;
    end

    // tick walk step
    t_dec  = rdata.tick > TICK_PRESSED;
    t_new  = rdata.tick - 4'd1;
    t_emit = t_dec && (t_new == TICK_PRESSED);
    t_go   = !(t_emit && hold_valid && !out_free);
  end

  // RAM port control
  always_comb begin
    mem_re    = 1'b0;
    mem_raddr = idx[AW-1:0];
    mem_we    = 1'b0;
    mem_waddr = idx[AW-1:0];
    mem_wdata = rdata;
    unique case (state)
      ST_T_RD, ST_S_RD, ST_R_RD: begin
        mem_re = !idx_end;
      end
      ST_T_CHK: begin
        mem_we    = t_dec && t_go;
        mem_wdata = '{row: rdata.row, col: rdata.col, tick: t_new};
      end
      ST_S_ACT: begin
        if (act_rel) begin
          if (!rb_self && rl_up && f_up) begin
            mem_we    = 1'b1;
            mem_waddr = i_up;
            mem_wdata = '{row: row_up[2:0], col: s_col, tick: TICK_RELEASING};
          end else if (!rb_self && rl_dn && f_dn) begin
            mem_we    = 1'b1;
            mem_waddr = i_dn;
            mem_wdata = '{row: row_dn[2:0], col: s_col, tick: TICK_RELEASING};
          end
        end else if (act_press) begin
          mem_we    = self_ok;
          mem_waddr = self_addr;
          mem_wdata = '{row: s_row, col: s_col,
                        tick: chord ? TICK_PRESSED : delay + TICK_PRESSED};
        end
      end
      ST_S_WR2: begin
        mem_we    = 1'b1;
        mem_waddr = part_idx;
        mem_wdata = '{row: part_row, col: s_col, tick: TICK_PRESSED};
      end
      ST_R_WR: begin
        mem_we    = 1'b1;
        mem_waddr = idx[AW-1:0] - AW'(1);
        mem_wdata = rdata;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rdata <= mem[mem_raddr];
    end
  end

  // ---------------------------------------------------------------------
  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state             <= ST_IDLE;
      press_delay_ticks <= DELAY_RESET;
      rows_in_use       <= ROWS_RESET;
      count             <= '0;
      idx               <= '0;
      press_bits        <= '0;
      releasing_bits    <= '0;
      logical_pressed   <= '0;
      hold_valid        <= 1'b0;
      res_valid         <= 1'b0;
      f_self            <= 1'b0;
      f_up              <= 1'b0;
      f_dn              <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == REG_PRESS_DELAY) begin
          press_delay_ticks <= cfg_data;
        end else begin
          rows_in_use <= cfg_data;
        end
      end

      if (res_valid && out_ready) begin
        res_valid <= 1'b0;
      end

      unique case (state)
        ST_IDLE: begin
          if (in_valid) begin
            s_row      <= phys_row;
            s_col      <= col;
            s_up       <= released;
            idx        <= '0;
            hold_valid <= 1'b0;
            f_self     <= 1'b0;
            f_up       <= 1'b0;
            f_dn       <= 1'b0;
            if (req_type == REQ_TICK) begin
              state <= ST_T_RD;
            end else if (in_ok) begin
              state <= ST_S_RD;
            end else begin
              state <= ST_FIN;
            end
          end
        end

        ST_T_RD: begin
          state <= idx_end ? ST_FIN : ST_T_CHK;
        end

        ST_T_CHK: begin
          if (t_go) begin
            if (t_emit) begin
              logical_pressed[lkey_idx({rdata.row, 1'b0}, rdata.col)] <= 1'b1;
              if (hold_valid) begin
                // previous event leaves, this one is held
                res_valid <= 1'b1;
                res_ev    <= 1'b1;
                res_kind  <= hold_kind;
                res_row   <= hold_row;
                res_col   <= hold_col;
                res_last  <= 1'b0;
              end
              hold_valid <= 1'b1;
              hold_kind  <= EV_PRESS;
              hold_row   <= {rdata.row, 1'b0};
              hold_col   <= rdata.col;
            end
            idx   <= idx + CW'(1);
            state <= ST_T_RD;
          end
        end

        ST_S_RD: begin
          state <= idx_end ? ST_S_ACT : ST_S_CHK;
        end

        ST_S_CHK: begin
          if (!f_self && rdata.row == s_row && rdata.col == s_col) begin
            f_self <= 1'b1;
            i_self <= idx[AW-1:0];
          end
          if (!f_up && {1'b0, rdata.row} == row_up && rdata.col == s_col) begin
            f_up <= 1'b1;
            i_up <= idx[AW-1:0];
            t_up <= rdata.tick;
          end
          if (!f_dn && {1'b0, rdata.row} == row_dn && rdata.col == s_col) begin
            f_dn <= 1'b1;
            i_dn <= idx[AW-1:0];
            t_dn <= rdata.tick;
          end
          idx   <= idx + CW'(1);
          state <= ST_S_RD;
        end

        ST_S_ACT: begin
          state <= ST_FIN;
          if (act_rel) begin
            if (!rb_self) begin
              hold_valid <= 1'b1;
              hold_kind  <= EV_RELEASE;
              hold_row   <= lr_rel;
              hold_col   <= s_col;
              logical_pressed[lkey_idx(lr_rel, s_col)] <= 1'b0;
              if (rl_up) begin
                releasing_bits[k_up] <= 1'b1;
                press_bits[k_up]     <= 1'b1;
              end else if (rl_dn) begin
                releasing_bits[k_dn] <= 1'b1;
                press_bits[k_dn]     <= 1'b1;
              end
            end
            releasing_bits[k_self] <= 1'b0;
            press_bits[k_self]     <= 1'b0;
            if (f_self) begin
              idx   <= CW'(i_self) + CW'(1);
              state <= ST_R_RD;
            end
          end else if (act_press) begin
            if (self_ok && !f_self) begin
              count <= count + CW'(1);
            end
            if (chord) begin
              hold_valid <= 1'b1;
              hold_kind  <= EV_PRESS;
              hold_row   <= lr_ch;
              hold_col   <= s_col;
              logical_pressed[lkey_idx(lr_ch, s_col)] <= 1'b1;
              press_bits[k_self] <= 1'b1;
              if (ch_up) begin
                press_bits[k_up] <= 1'b1;
                part_idx         <= i_up;
                part_row         <= row_up[2:0];
              end else begin
                press_bits[k_dn] <= 1'b1;
                part_idx         <= i_dn;
                part_row         <= row_dn[2:0];
              end
              state <= ST_S_WR2;
            end else if (self_ok) begin
              press_bits[k_self] <= 1'b1;
            end
          end
        end

        ST_S_WR2: begin
          state <= ST_FIN;
        end

        // compaction: shift entries behind the removed one down by one
        ST_R_RD: begin
          if (idx_end) begin
            count <= count - CW'(1);
            state <= ST_FIN;
          end else begin
            state <= ST_R_WR;
          end
        end

        ST_R_WR: begin
          idx   <= idx + CW'(1);
          state <= ST_R_RD;
        end

        ST_FIN: begin
          if (out_free) begin
            res_valid  <= 1'b1;
            res_ev     <= hold_valid;
            res_kind   <= hold_valid ? hold_kind : EV_PRESS;
            res_row    <= hold_valid ? hold_row : 4'd0;
            res_col    <= hold_valid ? hold_col : 5'd0;
            res_last   <= 1'b1;
            hold_valid <= 1'b0;
            state      <= ST_IDLE;
          end
        end

        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  assign in_ready    = state == ST_IDLE;
  assign cfg_ready   = 1'b1;
  assign out_valid   = res_valid;
  assign event_valid = res_ev;
  assign event_kind  = res_kind;
  assign logical_row = res_row;
  assign key_col     = res_col;
  assign last        = res_last;

endmodule

`default_nettype wire

FILE: tb/scan_checker.sv
`timescale 1ns / 1ps

module scan_checker
  import sck_pkg::*;
(
  input  wire        clk,
  input  wire        rst,
  input  wire        in_valid,
  input  wire        in_ready,
  input  wire        req_type,
  input  wire  [2:0] phys_row,
  input  wire  [4:0] col,
  input  wire        released,
  input  wire        out_valid,
  input  wire        out_ready,
  input  wire        event_valid,
  input  wire        event_kind,
  input  wire  [3:0] logical_row,
  input  wire  [4:0] key_col,
  input  wire        last,
  input  wire        cfg_valid,
  input  wire        cfg_ready,
  input  wire        cfg_index,
  input  wire  [3:0] cfg_data,
  output int         fail_count,
  output int         pending_events,
  output int         event_total
);

  localparam int DEPTH = 20;
  localparam int NROWS = 8;

  typedef struct packed {
    logic       valid;
    logic       kind;
    logic [3:0] lrow;
    logic [4:0] kcol;
    logic       lst;
  } key_event_t;

  key_event_t expected_events[$];

  entry_t      pend[DEPTH];
  int          pend_count;
  logic [31:0] pressed_map[NROWS];
  logic [31:0] releasing_map[NROWS];
  logic [31:0] logical_map[2*NROWS];
  logic [3:0]  delay_reg;
  logic [3:0]  rows_reg;
  key_event_t  step_events[$];

  function automatic int active_rows();
    return (rows_reg > NROWS) ? NROWS : int'(rows_reg);
  endfunction

  function automatic int find_slot(int r, int c);
    for (int i = 0; i < pend_count; i++)
      if (pend[i].row == r && pend[i].col == c) return i;
    return -1;
  endfunction

  function automatic bit is_waiting(int r, int c);
    int k;
    k = find_slot(r, c);
    return k >= 0 && pend[k].tick > TICK_PRESSED;
  endfunction

  function automatic bit put_slot(int r, int c, logic [3:0] t);
    int k;
    k = find_slot(r, c);
    if (k >= 0) begin
      pend[k].tick = t;
      return 1;
    end
    if (pend_count >= DEPTH) return 0;
    pend[pend_count] = '{row: r[2:0], col: c[4:0], tick: t};
    pend_count++;
    return 1;
  endfunction

  task automatic drop_slot(int r, int c);
    int j;
    j = 0;
    for (int i = 0; i < pend_count; i++) begin
      if (!(pend[i].row == r && pend[i].col == c)) begin
        pend[j] = pend[i];
        j++;
      end
    end
    pend_count = j;
  endtask

  task automatic add_event(logic kind, int lr, int c);
    key_event_t e;
    e = '{valid: 1'b1, kind: kind, lrow: lr[3:0], kcol: c[4:0], lst: 1'b0};
    step_events.push_back(e);
  endtask

  // predict events for one accepted input item
  task automatic scan_step(logic rt, int r, int c, logic up);
    logic [31:0] bit_m;
    int          nb;
    int          lr;
    int          d;
    key_event_t  e;
    step_events = {};
    bit_m = 32'd1 << c;
    if (rt == REQ_TICK) begin
      for (int i = 0; i < pend_count; i++) begin
        if (pend[i].tick > TICK_PRESSED) begin
          pend[i].tick--;
          if (pend[i].tick == TICK_PRESSED) begin
            add_event(EV_PRESS, 2 * pend[i].row, pend[i].col);
            logical_map[2 * pend[i].row][pend[i].col] = 1'b1;
          end
        end
      end
    end else if (r < active_rows()) begin
      if (up) begin
        if (pressed_map[r] & bit_m) begin
          if (!(releasing_map[r] & bit_m)) begin
            nb = 0;
            if (r + 1 < active_rows() && logical_map[2 * r + 1][c]) nb = 1;
            else if (r > 0 && logical_map[2 * r - 1][c]) nb = -1;
            lr = 2 * r + nb;
            add_event(EV_RELEASE, lr, c);
            logical_map[lr][c] = 1'b0;
            if (nb != 0) begin
              d = find_slot(r + nb, c);
              if (d >= 0) pend[d].tick = TICK_RELEASING;
              releasing_map[r + nb][c] = 1'b1;
              pressed_map[r + nb][c] = 1'b1;
            end
          end
          drop_slot(r, c);
          releasing_map[r][c] = 1'b0;
          pressed_map[r][c] = 1'b0;
        end
      end else if (!pressed_map[r][c] && !releasing_map[r][c]) begin
        nb = 0;
        if (r + 1 < active_rows() && is_waiting(r + 1, c)) nb = 1;
        else if (r > 0 && is_waiting(r - 1, c)) nb = -1;
        if (nb != 0) begin
          lr = 2 * r + nb;
          add_event(EV_PRESS, lr, c);
          logical_map[lr][c] = 1'b1;
          void'(put_slot(r, c, TICK_PRESSED));
          pressed_map[r][c] = 1'b1;
          void'(put_slot(r + nb, c, TICK_PRESSED));
          pressed_map[r + nb][c] = 1'b1;
        end else begin
          d = delay_reg;
          if (d < DELAY_MIN) d = DELAY_MIN;
          if (d > DELAY_MAX) d = DELAY_MAX;
          if (put_slot(r, c, 4'(d + TICK_PRESSED))) pressed_map[r][c] = 1'b1;
        end
      end
    end
    if (step_events.size() == 0) begin
      e = '0;
      e.lst = 1'b1;
      step_events.push_back(e);
    end else begin
      step_events[step_events.size() - 1].lst = 1'b1;
    end
    foreach (step_events[i]) expected_events.push_back(step_events[i]);
  endtask

  task automatic report_mismatch(string what, key_event_t got, key_event_t want);
    $display("MISMATCH %s: got v%0b k%0b row%0d col%0d last%0b, %s",
             what, got.valid, got.kind, got.lrow, got.kcol, got.lst,
             $sformatf("want v%0b k%0b row%0d col%0d last%0b",
                       want.valid, want.kind, want.lrow, want.kcol, want.lst));
    fail_count++;
  endtask

  always @(posedge clk) begin
    key_event_t got;
    key_event_t want;
    if (rst) begin
      for (int i = 0; i < NROWS; i++) begin
        pressed_map[i] = '0;
        releasing_map[i] = '0;
      end
      for (int i = 0; i < 2 * NROWS; i++) logical_map[i] = '0;
      delay_reg = DELAY_RESET;
      rows_reg = ROWS_RESET;
      pend_count = 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == REG_PRESS_DELAY) delay_reg = cfg_data;
        else rows_reg = cfg_data;
      end
      if (out_valid && out_ready) begin
        got = '{valid: event_valid, kind: event_kind, lrow: logical_row,
                kcol: key_col, lst: last};
        event_total++;
        if (expected_events.size() == 0) begin
          report_mismatch("unexpected event", got, '0);
        end else begin
          want = expected_events.pop_front();
          if (got !== want) report_mismatch("event", got, want);
        end
      end
      if (in_valid && in_ready) scan_step(req_type, phys_row, col, released);
    end
    pending_events = expected_events.size();
  end

  initial begin
    fail_count = 0;
    event_total = 0;
    pending_events = 0;
  end

endmodule

FILE: tb/testbench.sv
`timescale 1ns / 1ps

module testbench;
  import sck_pkg::*;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       in_valid = 1'b0;
  wire        in_ready;
  logic       req_type = REQ_SAMPLE;
  logic [2:0] phys_row = '0;
  logic [4:0] col = '0;
  logic       released = 1'b0;
  wire        out_valid;
  logic       out_ready = 1'b0;
  wire        event_valid;
  wire        event_kind;
  wire  [3:0] logical_row;
  wire  [4:0] key_col;
  wire        last;
  logic       cfg_valid = 1'b0;
  wire        cfg_ready;
  logic       cfg_index = REG_PRESS_DELAY;
  logic [3:0] cfg_data = '0;

  int fail_count;
  int pending_events;
  int event_total;

  // idle percentages for sender and receiver, set per phase
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int idle_cycles = 0;
  int items_sent = 0;
  bit timed_out = 1'b0;

  localparam int WATCHDOG_LIMIT = 20000;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  steno_chord_key_scanner dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .req_type(req_type), .phys_row(phys_row), .col(col), .released(released),
    .out_valid(out_valid), .out_ready(out_ready),
    .event_valid(event_valid), .event_kind(event_kind),
    .logical_row(logical_row), .key_col(key_col), .last(last),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  scan_checker checker_i (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .req_type(req_type), .phys_row(phys_row), .col(col), .released(released),
    .out_valid(out_valid), .out_ready(out_ready),
    .event_valid(event_valid), .event_kind(event_kind),
    .logical_row(logical_row), .key_col(key_col), .last(last),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data),
    .fail_count(fail_count), .pending_events(pending_events),
    .event_total(event_total)
  );

  // receiver: stalls by percentage, redrawn every edge
  always @(posedge clk) begin
    if (rst) out_ready <= 1'b0;
    else out_ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // watchdog: cycles with no accepted item on any channel
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT && !timed_out) begin
      timed_out = 1'b1;
      $display("Watchdog expired with %0d events outstanding", pending_events);
      $display("Verification failed");
      $finish;
    end
  end

  // one input item; sender gap drawn before raising valid, valid stays up
  // into the next item when there is no gap
  task automatic send_item(logic rt, int r, int c, logic up);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    req_type <= rt;
    phys_row <= r[2:0];
    col <= c[4:0];
    released <= up;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    items_sent++;
  endtask

  task automatic send_tick();
    send_item(REQ_TICK, $urandom_range(7), $urandom_range(31), 1'($urandom_range(1)));
  endtask

  // drain, then leave slack for a trailing table walk
  task automatic wait_quiet();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_events != 0) @(posedge clk);
    repeat (60) @(posedge clk);
  endtask

  task automatic write_reg(logic idx, logic [3:0] val);
    wait_quiet();
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
  endtask

  // random item mix: mostly chord/solo press-release in a few columns
  task automatic random_items(int count);
    int r;
    int c;
    for (int i = 0; i < count; i++) begin
      r = $urandom_range(7);
      c = ($urandom_range(3) == 0) ? $urandom_range(31) : $urandom_range(3);
      case ($urandom_range(9))
        0, 1, 2: send_tick();
        3, 4:    send_item(REQ_SAMPLE, r, c, 1'b1);
        5:       send_item(REQ_SAMPLE, r, c, 1'($urandom_range(1)));
        default: begin
          // press a pair of neighbours in one column
          send_item(REQ_SAMPLE, r, c, 1'b0);
          if (r < 7) send_item(REQ_SAMPLE, r + 1, c, 1'b0);
          i++;
        end
      endcase
    end
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: solo press expiring, chord, releases, short tap, edges
    write_reg(REG_PRESS_DELAY, 4'd0);
    send_item(REQ_SAMPLE, 0, 0, 1'b0);
    send_tick();
    send_tick();
    send_item(REQ_SAMPLE, 0, 0, 1'b1);
    send_item(REQ_SAMPLE, 7, 31, 1'b0);
    send_item(REQ_SAMPLE, 6, 31, 1'b0);
    send_item(REQ_SAMPLE, 7, 31, 1'b1);
    send_item(REQ_SAMPLE, 6, 31, 1'b1);
    send_item(REQ_SAMPLE, 3, 5, 1'b0);
    send_item(REQ_SAMPLE, 3, 5, 1'b1);
    send_item(REQ_SAMPLE, 4, 5, 1'b1);
    send_tick();
    write_reg(REG_ROWS_IN_USE, 4'd3);
    send_item(REQ_SAMPLE, 5, 2, 1'b0);
    send_item(REQ_SAMPLE, 2, 2, 1'b0);
    send_item(REQ_SAMPLE, 1, 2, 1'b0);
    send_item(REQ_SAMPLE, 2, 2, 1'b1);
    send_item(REQ_SAMPLE, 1, 2, 1'b1);
    write_reg(REG_ROWS_IN_USE, 4'd0);
    send_item(REQ_SAMPLE, 0, 9, 1'b0);
    write_reg(REG_ROWS_IN_USE, 4'd15);
    write_reg(REG_PRESS_DELAY, 4'd15);
    // fill the table past depth, then ticks to drain
    for (int c = 10; c < 32; c++) send_item(REQ_SAMPLE, 0, c, 1'b0);
    send_item(REQ_SAMPLE, 1, 10, 1'b0);
    repeat (14) send_tick();

    // random phases over register settings and idle mixes
    for (int ph = 0; ph < 4; ph++) begin
      write_reg(REG_PRESS_DELAY, 4'($urandom_range(1, 13)));
      write_reg(REG_ROWS_IN_USE, (ph == 3) ? 4'd1 : 4'($urandom_range(2, 8)));
      case (ph)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 62; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 62; end
        default: begin send_idle_pct = 22; recv_stall_pct = 22; end
      endcase
      random_items(105);
    end
    write_reg(REG_ROWS_IN_USE, 4'd8);
    send_idle_pct = 22;
    recv_stall_pct = 22;
    random_items(20);

    wait_quiet();
    $display("Sent %0d input items across 5 register/idle phases; %0d results checked",
             items_sent, event_total);
    if (fail_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
